@@ rtl/nzp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzp_pkg: shared types and codes of the nested zone cycle profiler
// Command and status codes, sequencer states and the zone table control group.
// ----------------------------------------------------------------------------
package nzp_pkg;

  // Fixed field widths of the command beat and the result beat.
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ZONE_IDX_W = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned HIT_W      = 32;

  // Event commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_PROF_START = 3'd0,
    CMD_ZONE_BEGIN = 3'd1,
    CMD_ZONE_END   = 3'd2,
    CMD_PROF_END   = 3'd3,
    CMD_READ_ZONE  = 3'd4
  } cmd_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD_ZONE  = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BEGIN_RD,
    S_BEGIN_WR,
    S_END_RD,
    S_END_ELAP,
    S_END_CHILD,
    S_END_TOTAL,
    S_END_INCL,
    S_PROF_END,
    S_READ_RD,
    S_READ_SUB,
    S_RESP
  } state_e;

  // Strobes from the sequencer to the zone table.
  typedef struct packed {
    logic rd_en;
    logic main_we;
    logic child_we;
  } tbl_ctrl_t;

endpackage

@@ rtl/nzp_zone_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzp_zone_table: per-zone accumulator storage
// Holds zone total, inclusive time and hit count in one memory and the
// children total in a second memory, so that a zone and its parent can be
// read and written in the same step even when they are the same zone.
// ----------------------------------------------------------------------------
module nzp_zone_table #(
  parameter int unsigned ZW = 6,
  parameter int unsigned TW = 64
) (
  input  logic                           clk_i,
  input  nzp_pkg::tbl_ctrl_t             ctrl_i,
  input  logic [ZW-1:0]                  main_rd_addr_i,
  input  logic [ZW-1:0]                  child_rd_addr_i,
  input  logic [ZW-1:0]                  main_wr_addr_i,
  input  logic [ZW-1:0]                  child_wr_addr_i,
  input  logic [TW-1:0]                  wr_total_i,
  input  logic [TW-1:0]                  wr_incl_i,
  input  logic [nzp_pkg::HIT_W-1:0]      wr_hits_i,
  input  logic [TW-1:0]                  wr_child_i,
  output logic [TW-1:0]                  rd_total_o,
  output logic [TW-1:0]                  rd_incl_o,
  output logic [nzp_pkg::HIT_W-1:0]      rd_hits_o,
  output logic [TW-1:0]                  rd_child_o
);
  import nzp_pkg::*;

  localparam int unsigned DEPTH = 1 << ZW;

  logic [TW-1:0]    total_mem [DEPTH];
  logic [TW-1:0]    incl_mem  [DEPTH];
  logic [HIT_W-1:0] hits_mem  [DEPTH];
  logic [TW-1:0]    child_mem [DEPTH];

  // Main memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.main_we) begin
      total_mem[main_wr_addr_i] <= wr_total_i;
      incl_mem[main_wr_addr_i]  <= wr_incl_i;
      hits_mem[main_wr_addr_i]  <= wr_hits_i;
    end
    if (ctrl_i.rd_en) begin
      rd_total_o <= total_mem[main_rd_addr_i];
      rd_incl_o  <= incl_mem[main_rd_addr_i];
      rd_hits_o  <= hits_mem[main_rd_addr_i];
    end
  end

  // Children memory: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.child_we) begin
      child_mem[child_wr_addr_i] <= wr_child_i;
    end
    if (ctrl_i.rd_en) begin
      rd_child_o <= child_mem[child_rd_addr_i];
    end
  end

endmodule

@@ rtl/nested_zone_cycle_profiler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_zone_cycle_profiler: hierarchical inclusive and exclusive zone timer
// Takes timestamped profiling events, keeps a nesting stack and per-zone
// totals, and answers each event with one result beat.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Handshake
//  -------   ---------------------------------------   ------------------------
//  command   command_i, zone_index_i, timestamp_i      start_i high, busy_o low
//  result    status_o, hit_count_o, exclusive_cycles_o, result_valid_o, one
//            inclusive_cycles_o, total_cycles_o        cycle, cannot be held
//
// A rejected event or an unknown command goes straight to the result beat;
// profile end first subtracts the total, zone begin reads the table and pushes
// a frame, zone read reads and subtracts, zone end reads the frame and updates
// elapsed, children, total and inclusive time, and profile start clears the
// zone table. One shared add/subtract unit takes one step a cycle; the zone
// table takes one access a cycle; profile start clears one entry a cycle.
// After reset the same clearing pass runs with busy_o high and no result.
// The result beat is not stalled; busy_o is low whenever a command may start.
//
module nested_zone_cycle_profiler #(
  parameter int unsigned ZONE_COUNT  = 64,
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned TIME_WIDTH  = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [nzp_pkg::CMD_W-1:0]        command_i,
  input  logic [nzp_pkg::ZONE_IDX_W-1:0]   zone_index_i,
  input  logic [TIME_WIDTH-1:0]            timestamp_i,
  output logic                             result_valid_o,
  output logic [nzp_pkg::STATUS_W-1:0]     status_o,
  output logic [nzp_pkg::HIT_W-1:0]        hit_count_o,
  output logic [TIME_WIDTH-1:0]            exclusive_cycles_o,
  output logic [TIME_WIDTH-1:0]            inclusive_cycles_o,
  output logic [TIME_WIDTH-1:0]            total_cycles_o
);
  import nzp_pkg::*;

  localparam int unsigned TW  = TIME_WIDTH;
  localparam int unsigned ZW  = $clog2(ZONE_COUNT);
  localparam int unsigned SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  // Sequencer and architectural state.
  state_e               state_q, state_d;
  logic                 emit_q;
  logic [ZW-1:0]        clr_q;
  logic [SPW-1:0]       sp_q;
  logic [ZONE_IDX_W-1:0] parent_q;
  logic [TW-1:0]        prof_start_q;
  logic [TW-1:0]        prof_total_q;

  // Latched command beat and working registers.
  cmd_e                 cmd_q;
  logic [ZONE_IDX_W-1:0] zone_q;
  logic [TW-1:0]        ts_q;
  logic [TW-1:0]        elapsed_q;
  logic [TW-1:0]        acc_q;

  // Result registers.
  status_e              status_q;
  logic [HIT_W-1:0]     hits_q;
  logic [TW-1:0]        excl_q;
  logic [TW-1:0]        incl_q;

  // Nesting stack memory with registered read data.
  logic [ZONE_IDX_W-1:0] stk_zone   [STACK_DEPTH];
  logic [ZONE_IDX_W-1:0] stk_parent [STACK_DEPTH];
  logic [TW-1:0]         stk_start  [STACK_DEPTH];
  logic [TW-1:0]         stk_saved  [STACK_DEPTH];
  logic [ZONE_IDX_W-1:0] stk_zone_rd_q;
  logic [ZONE_IDX_W-1:0] stk_parent_rd_q;
  logic [TW-1:0]         stk_start_rd_q;
  logic [TW-1:0]         stk_saved_rd_q;

  // Zone table interface.
  tbl_ctrl_t        tbl_ctrl;
  logic [ZW-1:0]    main_rd_addr;
  logic [ZW-1:0]    child_rd_addr;
  logic [ZW-1:0]    main_wr_addr;
  logic [ZW-1:0]    child_wr_addr;
  logic [TW-1:0]    wr_total;
  logic [TW-1:0]    wr_incl;
  logic [HIT_W-1:0] wr_hits;
  logic [TW-1:0]    wr_child;
  logic [TW-1:0]    rd_total;
  logic [TW-1:0]    rd_incl;
  logic [HIT_W-1:0] rd_hits;
  logic [TW-1:0]    rd_child;

  // Shared add/subtract unit.
  logic [TW-1:0] alu_a;
  logic [TW-1:0] alu_b;
  logic          alu_sub;
  logic [TW-1:0] alu_y;

  // Decode of an arriving beat.
  logic           accept;
  logic           zone_ok;
  logic           stack_full;
  logic           stack_empty;
  logic [SPW-1:0] sp_dec;
  status_e        status_new;

  assign accept      = start_i && (state_q == S_IDLE);
  assign zone_ok     = (zone_index_i != '0) && (32'(zone_index_i) < ZONE_COUNT);
  assign stack_full  = (sp_q == SPW'(STACK_DEPTH));
  assign stack_empty = (sp_q == '0);
  assign sp_dec      = sp_q - SPW'(1);

  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // Status that an arriving beat will report.
  always_comb begin
    status_new = ST_OK;
    case (cmd_e'(command_i))
      CMD_ZONE_BEGIN: begin
        if (!zone_ok) begin
          status_new = ST_BAD_ZONE;
        end else if (stack_full) begin
          status_new = ST_OVERFLOW;
        end
      end
      CMD_ZONE_END: begin
        if (stack_empty) begin
          status_new = ST_UNDERFLOW;
        end
      end
      CMD_READ_ZONE: begin
        if (!zone_ok) begin
          status_new = ST_BAD_ZONE;
        end
      end
      default: status_new = ST_OK;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == ZW'(ZONE_COUNT - 1)) begin
          state_d = emit_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          if (status_new != ST_OK) begin
            state_d = S_RESP;
          end else begin
            case (cmd_e'(command_i))
              CMD_PROF_START: state_d = S_CLEAR;
              CMD_ZONE_BEGIN: state_d = S_BEGIN_RD;
              CMD_ZONE_END:   state_d = S_END_RD;
              CMD_PROF_END:   state_d = S_PROF_END;
              CMD_READ_ZONE:  state_d = S_READ_RD;
              default:        state_d = S_RESP;
            endcase
          end
        end
      end
      S_BEGIN_RD:  state_d = S_BEGIN_WR;
      S_BEGIN_WR:  state_d = S_RESP;
      S_END_RD:    state_d = S_END_ELAP;
      S_END_ELAP:  state_d = S_END_CHILD;
      S_END_CHILD: state_d = S_END_TOTAL;
      S_END_TOTAL: state_d = S_END_INCL;
      S_END_INCL:  state_d = S_RESP;
      S_PROF_END:  state_d = S_RESP;
      S_READ_RD:   state_d = S_READ_SUB;
      S_READ_SUB:  state_d = S_RESP;
      S_RESP:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Table strobes, addresses, write data and unit operands per step.
  always_comb begin
    tbl_ctrl      = '0;
    main_rd_addr  = ZW'(zone_q);
    child_rd_addr = ZW'(zone_q);
    main_wr_addr  = ZW'(stk_zone_rd_q);
    child_wr_addr = ZW'(stk_parent_rd_q);
    wr_total      = acc_q;
    wr_incl       = alu_y;
    wr_hits       = rd_hits + HIT_W'(1);
    wr_child      = alu_y;
    alu_a         = rd_total;
    alu_b         = rd_child;
    alu_sub       = 1'b1;
    unique case (state_q) inside
      S_CLEAR: begin
        tbl_ctrl.main_we  = 1'b1;
        tbl_ctrl.child_we = 1'b1;
        main_wr_addr      = clr_q;
        child_wr_addr     = clr_q;
        wr_total          = '0;
        wr_incl           = '0;
        wr_hits           = '0;
        wr_child          = '0;
      end
      S_BEGIN_RD, S_READ_RD: begin
        tbl_ctrl.rd_en = 1'b1;
      end
      S_END_ELAP: begin
        tbl_ctrl.rd_en = 1'b1;
        main_rd_addr   = ZW'(stk_zone_rd_q);
        child_rd_addr  = ZW'(stk_parent_rd_q);
        alu_a          = ts_q;
        alu_b          = stk_start_rd_q;
      end
      S_END_CHILD: begin
        tbl_ctrl.child_we = 1'b1;
        alu_a             = rd_child;
        alu_b             = elapsed_q;
        alu_sub           = 1'b0;
      end
      S_END_TOTAL: begin
        alu_a   = rd_total;
        alu_b   = elapsed_q;
        alu_sub = 1'b0;
      end
      S_END_INCL: begin
        tbl_ctrl.main_we = 1'b1;
        alu_a            = stk_saved_rd_q;
        alu_b            = elapsed_q;
        alu_sub          = 1'b0;
      end
      S_PROF_END: begin
        alu_a = ts_q;
        alu_b = prof_start_q;
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  // Sequencer, clear counter and profile state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      emit_q       <= 1'b0;
      clr_q        <= '0;
      sp_q         <= '0;
      parent_q     <= '0;
      prof_start_q <= '0;
      prof_total_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + ZW'(1);
      end
      if (accept && (cmd_e'(command_i) == CMD_PROF_START)) begin
        emit_q       <= 1'b1;
        clr_q        <= '0;
        sp_q         <= '0;
        parent_q     <= '0;
        prof_start_q <= timestamp_i;
        prof_total_q <= '0;
      end
      if (state_q == S_BEGIN_WR) begin
        sp_q     <= sp_q + SPW'(1);
        parent_q <= zone_q;
      end
      if (state_q == S_END_INCL) begin
        sp_q     <= sp_dec;
        parent_q <= stk_parent_rd_q;
      end
      if (state_q == S_PROF_END) begin
        prof_total_q <= alu_y;
      end
    end
  end

  // Command beat capture, working registers and result fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(command_i);
      zone_q   <= zone_index_i;
      ts_q     <= timestamp_i;
      status_q <= status_new;
      hits_q   <= '0;
      excl_q   <= '0;
      incl_q   <= '0;
    end
    if (state_q == S_END_ELAP) begin
      elapsed_q <= alu_y;
    end
    if (state_q == S_END_TOTAL) begin
      acc_q <= alu_y;
    end
    if ((state_q == S_READ_SUB) && (cmd_q == CMD_READ_ZONE)) begin
      hits_q <= rd_hits;
      excl_q <= alu_y;
      incl_q <= rd_incl;
    end
  end

  // Stack push on zone begin and registered read of the top frame on zone end.
  always_ff @(posedge clk_i) begin
    if (state_q == S_BEGIN_WR) begin
      stk_zone[sp_q[SW-1:0]]   <= zone_q;
      stk_parent[sp_q[SW-1:0]] <= parent_q;
      stk_start[sp_q[SW-1:0]]  <= ts_q;
      stk_saved[sp_q[SW-1:0]]  <= rd_incl;
    end
    if (state_q == S_END_RD) begin
      stk_zone_rd_q   <= stk_zone[sp_dec[SW-1:0]];
      stk_parent_rd_q <= stk_parent[sp_dec[SW-1:0]];
      stk_start_rd_q  <= stk_start[sp_dec[SW-1:0]];
      stk_saved_rd_q  <= stk_saved[sp_dec[SW-1:0]];
    end
  end

  nzp_zone_table #(
    .ZW (ZW),
    .TW (TW)
  ) u_zone_table (
    .clk_i           (clk_i),
    .ctrl_i          (tbl_ctrl),
    .main_rd_addr_i  (main_rd_addr),
    .child_rd_addr_i (child_rd_addr),
    .main_wr_addr_i  (main_wr_addr),
    .child_wr_addr_i (child_wr_addr),
    .wr_total_i      (wr_total),
    .wr_incl_i       (wr_incl),
    .wr_hits_i       (wr_hits),
    .wr_child_i      (wr_child),
    .rd_total_o      (rd_total),
    .rd_incl_o       (rd_incl),
    .rd_hits_o       (rd_hits),
    .rd_child_o      (rd_child)
  );

  // Result beat and handshake outputs.
  assign busy_o             = (state_q != S_IDLE);
  assign result_valid_o     = (state_q == S_RESP);
  assign status_o           = status_q;
  assign hit_count_o        = hits_q;
  assign exclusive_cycles_o = excl_q;
  assign inclusive_cycles_o = incl_q;
  assign total_cycles_o     = prof_total_q;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the nested zone cycle profiler
// Drives profiling event beats through the start/busy handshake, predicts every
// result beat with a behavioural copy of the zone table and nesting stack, and
// checks each result field against the oldest prediction still outstanding.
// A short table of directed events comes first, then random profiling sessions
// with nesting, recursion, wrap-around timestamps and malformed events.
// ----------------------------------------------------------------------------
module tb_top;
  import nzp_pkg::*;

  localparam int unsigned ZONES        = 64;
  localparam int unsigned STACK_LEVELS = 16;
  localparam int unsigned TW           = 64;
  localparam int          ITEM_TARGET  = 1650;
  localparam int          CYCLE_LIMIT  = 1000000;

  // Command codes the block does not define; they must leave the state alone.
  localparam logic [CMD_W-1:0] CMD_RESERVED_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESERVED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RESERVED_7 = 3'd7;
  localparam logic [ZONE_IDX_W-1:0] NO_ZONE   = '0;
  localparam logic [TW-1:0] TS_MAX            = '1;

  // One result beat as the block presents it.
  typedef struct packed {
    status_e        status;
    logic [HIT_W-1:0] hits;
    logic [TW-1:0]  excl;
    logic [TW-1:0]  incl;
    logic [TW-1:0]  total;
  } zone_result_t;

  // One row of the directed event list.
  typedef struct {
    logic [CMD_W-1:0]      cmd;
    logic [ZONE_IDX_W-1:0] zone;
    logic [TW-1:0]         ts;
    int                    reps;
    bit                    fixed;
    zone_result_t          res;
  } event_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start_i = 1'b0;
  logic [CMD_W-1:0]       command_i = '0;
  logic [ZONE_IDX_W-1:0]  zone_index_i = '0;
  logic [TW-1:0]          timestamp_i = '0;
  logic                   busy_o;
  logic                   result_valid_o;
  logic [STATUS_W-1:0]    status_o;
  logic [HIT_W-1:0]       hit_count_o;
  logic [TW-1:0]          exclusive_cycles_o;
  logic [TW-1:0]          inclusive_cycles_o;
  logic [TW-1:0]          total_cycles_o;

  // Shadow of the profiler state.
  logic [TW-1:0]          zone_sum   [ZONES];
  logic [TW-1:0]          zone_kids  [ZONES];
  logic [TW-1:0]          zone_incl  [ZONES];
  logic [HIT_W-1:0]       zone_visits[ZONES];
  logic [ZONE_IDX_W-1:0]  frame_zone  [STACK_LEVELS];
  logic [ZONE_IDX_W-1:0]  frame_parent[STACK_LEVELS];
  logic [TW-1:0]          frame_start [STACK_LEVELS];
  logic [TW-1:0]          frame_saved [STACK_LEVELS];
  int                     nest_depth = 0;
  logic [ZONE_IDX_W-1:0]  open_parent = '0;
  logic [TW-1:0]          prof_t0 = '0;
  logic [TW-1:0]          prof_len = '0;

  zone_result_t           pending_results[$];
  zone_result_t           oldest_result;
  event_row_t             event_rows[$];
  int                     fail_cnt = 0;
  int                     beats_sent = 0;
  int                     cycle_cnt = 0;
  bit                     no_idle = 1'b0;

  nested_zone_cycle_profiler #(
    .ZONE_COUNT (ZONES),
    .STACK_DEPTH(STACK_LEVELS),
    .TIME_WIDTH (TW)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .command_i         (command_i),
    .zone_index_i      (zone_index_i),
    .timestamp_i       (timestamp_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .hit_count_o       (hit_count_o),
    .exclusive_cycles_o(exclusive_cycles_o),
    .inclusive_cycles_o(inclusive_cycles_o),
    .total_cycles_o    (total_cycles_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one event to the shadow state and returns the result it produces.
  function automatic zone_result_t profile_event(input logic [CMD_W-1:0] cmd,
                                                 input logic [ZONE_IDX_W-1:0] zone,
                                                 input logic [TW-1:0] ts);
    zone_result_t r;
    logic [ZONE_IDX_W-1:0] z;
    logic [ZONE_IDX_W-1:0] p;
    logic [TW-1:0] elapsed;
    r.status = ST_OK;
    r.hits   = '0;
    r.excl   = '0;
    r.incl   = '0;
    case (cmd)
      CMD_PROF_START: begin
        for (int i = 0; i < ZONES; i++) begin
          zone_sum[i]    = '0;
          zone_kids[i]   = '0;
          zone_incl[i]   = '0;
          zone_visits[i] = '0;
        end
        nest_depth  = 0;
        open_parent = '0;
        prof_len    = '0;
        prof_t0     = ts;
      end
      CMD_ZONE_BEGIN: begin
        if (zone == NO_ZONE) begin
          r.status = ST_BAD_ZONE;
        end else if (nest_depth >= STACK_LEVELS) begin
          r.status = ST_OVERFLOW;
        end else begin
          frame_zone[nest_depth]   = zone;
          frame_parent[nest_depth] = open_parent;
          frame_start[nest_depth]  = ts;
          frame_saved[nest_depth]  = zone_incl[zone];
          nest_depth++;
          open_parent = zone;
        end
      end
      CMD_ZONE_END: begin
        if (nest_depth == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          nest_depth--;
          z       = frame_zone[nest_depth];
          p       = frame_parent[nest_depth];
          elapsed = ts - frame_start[nest_depth];
          open_parent    = p;
          zone_kids[p]   = zone_kids[p] + elapsed;
          zone_incl[z]   = frame_saved[nest_depth] + elapsed;
          zone_sum[z]    = zone_sum[z] + elapsed;
          zone_visits[z] = zone_visits[z] + 1'b1;
        end
      end
      CMD_PROF_END: prof_len = ts - prof_t0;
      CMD_READ_ZONE: begin
        if (zone == NO_ZONE) begin
          r.status = ST_BAD_ZONE;
        end else begin
          r.hits = zone_visits[zone];
          r.excl = zone_sum[zone] - zone_kids[zone];
          r.incl = zone_incl[zone];
        end
      end
      default: ;
    endcase
    r.total = prof_len;
    return r;
  endfunction

  // Directed row whose result is worked out by the shadow model.
  function automatic event_row_t calc_row(input logic [CMD_W-1:0] cmd,
                                          input logic [ZONE_IDX_W-1:0] zone,
                                          input logic [TW-1:0] ts, input int reps = 1);
    event_row_t row;
    row.cmd   = cmd;
    row.zone  = zone;
    row.ts    = ts;
    row.reps  = reps;
    row.fixed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  // Directed row with a known result; the zone fields are zero in all of them.
  function automatic event_row_t lit_row(input logic [CMD_W-1:0] cmd,
                                         input logic [ZONE_IDX_W-1:0] zone,
                                         input logic [TW-1:0] ts, input status_e status,
                                         input logic [TW-1:0] total);
    event_row_t row;
    row = calc_row(cmd, zone, ts);
    row.fixed      = 1'b1;
    row.res.status = status;
    row.res.total  = total;
    return row;
  endfunction

  // Random idle time before a beat: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one event beat, waits for it to be taken and records its result.
  task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [ZONE_IDX_W-1:0] zone,
                            input logic [TW-1:0] ts, input bit fixed = 1'b0,
                            input zone_result_t fixed_res = '0);
    int gap;
    zone_result_t r;
    gap = idle_cycles();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    command_i    <= cmd;
    zone_index_i <= zone;
    timestamp_i  <= ts;
    do @(posedge clk_i); while (busy_o);
    r = profile_event(cmd, zone, ts);
    pending_results.push_back(fixed ? fixed_res : r);
    beats_sent++;
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic drain_results();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Time between events: mostly short, sometimes large enough to wrap.
  function automatic logic [TW-1:0] tick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) return TW'($urandom_range(0, 300));
    if (pick < 97) return TW'($urandom);
    return {$urandom, $urandom};
  endfunction

  // A narrow pool of zones forces recursion and shared parents.
  function automatic logic [ZONE_IDX_W-1:0] pick_zone(input bit narrow);
    if (narrow) return ZONE_IDX_W'($urandom_range(1, 4));
    return ZONE_IDX_W'($urandom_range(1, 63));
  endfunction

  // One profiling session with random nesting and reads, now and then malformed.
  task automatic run_session();
    logic [TW-1:0] now;
    int max_nest;
    int steps;
    bit narrow;
    int unsigned pick;
    case ($urandom_range(0, 2))
      0:       now = {$urandom, $urandom};
      1:       now = TW'($urandom_range(0, 1000));
      default: now = TS_MAX - TW'($urandom_range(0, 2000));
    endcase
    narrow   = ($urandom_range(0, 1) == 0);
    max_nest = ($urandom_range(0, 3) == 0) ? STACK_LEVELS + 2 : $urandom_range(1, 6);
    steps    = $urandom_range(5, 40);
    no_idle  = ($urandom_range(0, 3) == 0);
    send_event(CMD_PROF_START, pick_zone(narrow), now);
    repeat (steps) begin
      now += tick_gap();
      pick = $urandom_range(0, 99);
      if (pick < 45 && nest_depth < max_nest) begin
        send_event(CMD_ZONE_BEGIN,
                   ($urandom_range(0, 99) == 0) ? NO_ZONE : pick_zone(narrow), now);
      end else if (pick < 80) begin
        send_event(CMD_ZONE_END, pick_zone(narrow), now);
      end else if (pick < 96) begin
        send_event(CMD_READ_ZONE, pick_zone(narrow), now);
      end else begin
        send_event(CMD_PROF_END, pick_zone(narrow), now);
      end
    end
    // Usually unwind every open zone; sometimes leave some open or pop one too many.
    if ($urandom_range(0, 9) != 0) begin
      while (nest_depth > 0) begin
        now += tick_gap();
        send_event(CMD_ZONE_END, pick_zone(narrow), now);
      end
    end
    if ($urandom_range(0, 9) == 0) send_event(CMD_ZONE_END, NO_ZONE, now);
    now += tick_gap();
    send_event(CMD_PROF_END, pick_zone(narrow), now);
    repeat ($urandom_range(1, 4)) send_event(CMD_READ_ZONE, pick_zone(narrow), now);
  endtask

  // Compares one result field and counts a mismatch.
  task automatic compare_field(input string name, input logic [TW-1:0] want,
                               input logic [TW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Result checker: every strobed beat must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no event outstanding");
        fail_cnt++;
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("status", TW'(oldest_result.status), TW'(status_o));
        compare_field("hit_count", TW'(oldest_result.hits), TW'(hit_count_o));
        compare_field("exclusive_cycles", oldest_result.excl, exclusive_cycles_o);
        compare_field("inclusive_cycles", oldest_result.incl, inclusive_cycles_o);
        compare_field("total_cycles", oldest_result.total, total_cycles_o);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    // Fresh state after reset, error paths, wrap of the total, then nesting
    // with recursion, a full stack and an emptied one.
    event_rows.push_back(lit_row(CMD_READ_ZONE, 6'd5, '0, ST_OK, '0));
    event_rows.push_back(lit_row(CMD_READ_ZONE, NO_ZONE, TS_MAX, ST_BAD_ZONE, '0));
    event_rows.push_back(lit_row(CMD_ZONE_END, 6'd63, '0, ST_UNDERFLOW, '0));
    event_rows.push_back(lit_row(CMD_ZONE_BEGIN, NO_ZONE, 64'd7, ST_BAD_ZONE, '0));
    event_rows.push_back(lit_row(CMD_PROF_START, 6'd1, 64'd100, ST_OK, '0));
    event_rows.push_back(lit_row(CMD_PROF_END, 6'd1, 64'd50, ST_OK,
                                 64'hFFFF_FFFF_FFFF_FFCE));
    event_rows.push_back(lit_row(CMD_PROF_START, 6'd63, TS_MAX, ST_OK, '0));
    event_rows.push_back(calc_row(CMD_ZONE_BEGIN, 6'd63, '0));
    event_rows.push_back(calc_row(CMD_ZONE_BEGIN, 6'd1, 64'd10));
    event_rows.push_back(calc_row(CMD_ZONE_BEGIN, 6'd1, 64'd20));
    event_rows.push_back(calc_row(CMD_ZONE_END, NO_ZONE, 64'd25));
    event_rows.push_back(calc_row(CMD_ZONE_END, NO_ZONE, 64'd40));
    event_rows.push_back(calc_row(CMD_READ_ZONE, 6'd1, 64'd41));
    event_rows.push_back(calc_row(CMD_ZONE_END, NO_ZONE, TS_MAX));
    event_rows.push_back(calc_row(CMD_READ_ZONE, 6'd63, TS_MAX));
    event_rows.push_back(lit_row(CMD_RESERVED_5, 6'd63, TS_MAX, ST_OK, '0));
    event_rows.push_back(calc_row(CMD_RESERVED_6, 6'd2, 64'd3));
    event_rows.push_back(calc_row(CMD_RESERVED_7, 6'd0, '0));
    event_rows.push_back(lit_row(CMD_PROF_END, NO_ZONE, 64'd5, ST_OK, 64'd6));
    event_rows.push_back(calc_row(CMD_ZONE_BEGIN, 6'd2, 64'd500, STACK_LEVELS));
    event_rows.push_back(lit_row(CMD_ZONE_BEGIN, 6'd3, 64'd600, ST_OVERFLOW, 64'd6));
    event_rows.push_back(calc_row(CMD_ZONE_END, NO_ZONE, 64'd1000, STACK_LEVELS));
    event_rows.push_back(lit_row(CMD_ZONE_END, NO_ZONE, 64'd1001, ST_UNDERFLOW, 64'd6));
    event_rows.push_back(calc_row(CMD_READ_ZONE, 6'd2, 64'd1002));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (event_rows[i]) begin
      repeat (event_rows[i].reps) begin
        send_event(event_rows[i].cmd, event_rows[i].zone, event_rows[i].ts,
                   event_rows[i].fixed, event_rows[i].res);
      end
    end
    drain_results();

    // Mostly sessions, some noise beats, and an occasional full drain.
    beats_sent = 0;
    while (beats_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          no_idle = 1'b0;
          repeat ($urandom_range(1, 5)) begin
            send_event(CMD_W'($urandom_range(0, 7)), ZONE_IDX_W'($urandom_range(0, 63)),
                       {$urandom, $urandom});
          end
        end
        3:       drain_results();
        default: run_session();
      endcase
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (ZONES + 8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
